>>> rtl/core/scfcc_pkg.sv
package scfcc_pkg;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_CODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLY_CODE = 1'd1;

   localparam logic [7:0] COMMAND_CODE_RESET = 8'd221;
   localparam logic [7:0] REPLY_CODE_RESET = 8'd68;

   // request kinds carried on tuser
   localparam logic OP_BUILD = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // result status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_RESPONSE = 3'd1;
   localparam logic [2:0] ST_INCOMPLETE = 3'd2;
   localparam logic [2:0] ST_BAD_CRC = 3'd3;
   localparam logic [2:0] ST_WRONG_REPLY = 3'd4;

   localparam logic [2:0] FRAME_LEN = 3'd6;

   // CRC-16/CMS: poly 0x8005, init 0xFFFF, MSB first, no final xor
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_cur, input logic [7:0] din);
      logic [15:0] c;
      c = crc_cur ^ {din, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/core/servo_command_frame_crc_check.sv
// Channel  Dir  Width  Contents
// req      in   80+1   tdata: servo_id, position_code, rx_count, rx_byte0..5; tuser: op
// rsp      out  80     tdata: tx_byte0..5, status, ack_word, sent_position
// csr      in   1+1+8  write enable, register index, write data
//
// A request passes an input register, the CRC and check logic, then the result register.
// One frame per cycle when the result side takes every cycle; a stalled result holds in
// the output register while the input register still takes one more item. Reset is
// synchronous; it empties both stages and restores the command and reply codes.
module servo_command_frame_crc_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] servo_id, [21:8] position_code, [24:22] rx_count, [32:25] rx_byte0,
   // [40:33] rx_byte1, [48:41] rx_byte2, [56:49] rx_byte3, [64:57] rx_byte4,
   // [72:65] rx_byte5, [79:73] zero
   input  logic [scfcc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] op
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] tx_byte0, [15:8] tx_byte1, [22:16] tx_byte2, [29:23] tx_byte3,
   // [37:30] tx_byte4, [45:38] tx_byte5, [48:46] status, [63:49] ack_word,
   // [77:64] sent_position, [79:78] zero
   output logic [scfcc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [scfcc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scfcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import scfcc_pkg::*;

   logic [7:0] command_code_ff, command_code_in;
   logic [7:0] reply_code_ff, reply_code_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_op_ff, s1_op_in;
   logic [72:0]           s1_data_ff, s1_data_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic        out_load;
   logic        s1_load;
   logic [7:0]  servo_id;
   logic [13:0] position_code;
   logic [2:0]  rx_count;
   logic [7:0]  rx_byte0, rx_byte1, rx_byte2, rx_byte3, rx_byte4, rx_byte5;
   logic [7:0]  crc_b0, crc_b1, crc_b2, crc_b3;
   logic [15:0] crc_val;
   logic [7:0]  tx_byte0, tx_byte1, tx_byte4, tx_byte5;
   logic [6:0]  tx_byte2, tx_byte3;
   logic [2:0]  status;
   logic [14:0] ack_word;
   logic [13:0] sent_position;

   assign out_load = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_load;
   assign s1_load = req_tvalid && req_tready;

   always_comb begin
      command_code_in = command_code_ff;
      reply_code_in = reply_code_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COMMAND_CODE: command_code_in = csr_wdata;
            CSR_REPLY_CODE:   reply_code_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   // input stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in = s1_op_ff;
      s1_data_in = s1_data_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      if (s1_load) begin
         s1_op_in = req_tuser;
         s1_data_in = req_tdata[72:0];
      end
   end

   assign servo_id = s1_data_ff[7:0];
   assign position_code = s1_data_ff[21:8];
   assign rx_count = s1_data_ff[24:22];
   assign rx_byte0 = s1_data_ff[32:25];
   assign rx_byte1 = s1_data_ff[40:33];
   assign rx_byte2 = s1_data_ff[48:41];
   assign rx_byte3 = s1_data_ff[56:49];
   assign rx_byte4 = s1_data_ff[64:57];
   assign rx_byte5 = s1_data_ff[72:65];

   // one CRC unit, fed the built frame or the received one
   always_comb begin
      if (s1_op_ff == OP_BUILD) begin
         crc_b0 = command_code_ff;
         crc_b1 = servo_id;
         crc_b2 = {1'b0, position_code[13:7]};
         crc_b3 = {1'b0, position_code[6:0]};
      end else begin
         crc_b0 = rx_byte0;
         crc_b1 = rx_byte1;
         crc_b2 = rx_byte2;
         crc_b3 = rx_byte3;
      end
      crc_val = crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, crc_b0), crc_b1), crc_b2), crc_b3);
   end

   always_comb begin
      tx_byte0 = '0;
      tx_byte1 = '0;
      tx_byte2 = '0;
      tx_byte3 = '0;
      tx_byte4 = '0;
      tx_byte5 = '0;
      status = ST_OK;
      ack_word = '0;
      sent_position = '0;
      if (s1_op_ff == OP_BUILD) begin
         tx_byte0 = command_code_ff;
         tx_byte1 = servo_id;
         tx_byte2 = position_code[13:7];
         tx_byte3 = position_code[6:0];
         tx_byte4 = crc_val[15:8];
         tx_byte5 = crc_val[7:0];
         sent_position = position_code;
      end else if (rx_count == 3'd0) begin
         status = ST_NO_RESPONSE;
      end else if (rx_count != FRAME_LEN) begin
         status = ST_INCOMPLETE;
      end else if (crc_val != {rx_byte4, rx_byte5}) begin
         status = ST_BAD_CRC;
      end else if (rx_byte0 != reply_code_ff) begin
         status = ST_WRONG_REPLY;
      end else begin
         // bit 7 of byte three overlaps bit 0 of byte two
         ack_word = {rx_byte2, 7'd0} | {7'd0, rx_byte3};
      end
   end

   // result stage
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      if (out_load) begin
         out_valid_in = s1_valid_ff;
         out_data_in = {2'b00, sent_position, ack_word, status, tx_byte5, tx_byte4,
                        tx_byte3, tx_byte2, tx_byte1, tx_byte0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_code_ff <= COMMAND_CODE_RESET;
         reply_code_ff <= REPLY_CODE_RESET;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         command_code_ff <= command_code_in;
         reply_code_ff <= reply_code_in;
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= s1_op_in;
      s1_data_ff <= s1_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

endmodule

>>> rtl/core/scfcc_checker.sv
module scfcc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [scfcc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import scfcc_pkg::*;

   logic [2:0]  rsp_status;
   logic [14:0] rsp_ack;
   logic [13:0] rsp_sent;

   assign rsp_status = rsp_tdata[48:46];
   assign rsp_ack = rsp_tdata[63:49];
   assign rsp_sent = rsp_tdata[77:64];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing comes out of an emptied pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a failed check carries no frame, no echo and no acknowledge
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != ST_OK |->
         rsp_tdata[45:0] == '0 && rsp_ack == '0 && rsp_sent == '0)
      else $error("failed check carries payload");

   // a built frame never reports an acknowledge
   a_build_no_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_sent != '0 |-> rsp_status == ST_OK && rsp_ack == '0)
      else $error("built frame carries status or acknowledge");

endmodule

bind servo_command_frame_crc_check scfcc_checker u_scfcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/servo_command_frame_crc_check_test.sv
`timescale 1ns / 1ps

module servo_command_frame_crc_check_test;
   import scfcc_pkg::*;

   localparam int IDLE_PCT = 10;
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      logic             op;
      logic [7:0]       servo_id;
      logic [13:0]      position_code;
      logic [2:0]       rx_count;
      logic [5:0][7:0]  rx;
   } servo_req_type;

   typedef struct packed {
      logic [7:0]  tx0;
      logic [7:0]  tx1;
      logic [6:0]  tx2;
      logic [6:0]  tx3;
      logic [7:0]  tx4;
      logic [7:0]  tx5;
      logic [2:0]  status;
      logic [14:0] ack_word;
      logic [13:0] sent_position;
   } servo_rsp_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [7:0] servo_id, [21:8] position_code, [24:22] rx_count, [72:25] rx_byte0..5, [79:73] zero
   logic [REQ_DATA_W-1:0]  req_tdata;
   // [0] op
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [7:0] tx_byte0, [15:8] tx_byte1, [22:16] tx_byte2, [29:23] tx_byte3, [37:30] tx_byte4,
   // [45:38] tx_byte5, [48:46] status, [63:49] ack_word, [77:64] sent_position, [79:78] zero
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   servo_req_type  pending_frames[$];
   servo_rsp_type  expected_results[$];
   servo_req_type  req_cur;
   bit             req_fired;
   bit             calm;
   int unsigned    mismatches;
   logic [7:0]     cmd_code = COMMAND_CODE_RESET;
   logic [7:0]     rpl_code = REPLY_CODE_RESET;

   servo_command_frame_crc_check u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // bit-serial CRC-16/CMS over four bytes, first byte in the top bits
   function automatic logic [15:0] cms_crc(input logic [31:0] msg);
      logic [15:0] r;
      r = CRC_INIT;
      for (int i = 31; i >= 0; i--) begin
         if (r[15] ^ msg[i]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic servo_rsp_type predict_frame(input servo_req_type f);
      servo_rsp_type r;
      logic [15:0] crc;
      r = '0;
      if (f.op == OP_BUILD) begin
         r.tx0 = cmd_code;
         r.tx1 = f.servo_id;
         r.tx2 = f.position_code[13:7];
         r.tx3 = f.position_code[6:0];
         crc = cms_crc({r.tx0, r.tx1, 1'b0, r.tx2, 1'b0, r.tx3});
         r.tx4 = crc[15:8];
         r.tx5 = crc[7:0];
         r.sent_position = f.position_code;
      end else if (f.rx_count == 3'd0) begin
         r.status = ST_NO_RESPONSE;
      end else if (f.rx_count != FRAME_LEN) begin
         r.status = ST_INCOMPLETE;
      end else if (cms_crc({f.rx[0], f.rx[1], f.rx[2], f.rx[3]}) != {f.rx[4], f.rx[5]}) begin
         r.status = ST_BAD_CRC;
      end else if (f.rx[0] != rpl_code) begin
         r.status = ST_WRONG_REPLY;
      end else begin
         r.status = ST_OK;
         // bit 7 of byte three lands on bit 0 of byte two
         r.ack_word = {f.rx[2], 7'b0} | {7'b0, f.rx[3]};
      end
      return r;
   endfunction

   function automatic servo_req_type raw_frame();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return servo_req_type'(raw[$bits(servo_req_type)-1:0]);
   endfunction

   function automatic servo_req_type build_frame(input logic [7:0] id, input logic [13:0] pos);
      servo_req_type f;
      f = raw_frame();
      f.op = OP_BUILD;
      f.servo_id = id;
      f.position_code = pos;
      return f;
   endfunction

   function automatic servo_req_type good_reply(input logic [7:0] code, b1, b2, b3);
      servo_req_type f;
      logic [15:0] crc;
      f = raw_frame();
      f.op = OP_CHECK;
      f.rx_count = FRAME_LEN;
      crc = cms_crc({code, b1, b2, b3});
      f.rx = {crc[7:0], crc[15:8], b3, b2, b1, code};
      return f;
   endfunction

   // a mix of builds, well-formed replies, corrupted replies and noise
   function automatic servo_req_type random_frame();
      servo_req_type f;
      int unsigned pick;
      logic [7:0] code;
      pick = $urandom_range(99);
      f = raw_frame();
      code = ($urandom_range(7) == 0) ? 8'($urandom) : rpl_code;
      if (pick < 35) begin
         f.op = OP_BUILD;
      end else if (pick < 75) begin
         f = good_reply(code, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 85) begin
         f = good_reply(rpl_code, 8'($urandom), 8'($urandom), 8'($urandom));
         f.rx = f.rx ^ (48'd1 << $urandom_range(47));
      end else begin
         f.op = OP_CHECK;
      end
      return f;
   endfunction

   task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_COMMAND_CODE) begin
         cmd_code = val;
      end else begin
         rpl_code = val;
      end
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_frames.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver: hold the item until it transfers, then fetch the next one
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_frames.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_cur = pending_frames.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, req_cur.rx, req_cur.rx_count, req_cur.position_code,
                          req_cur.servo_id};
            req_tuser <= req_cur.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      servo_rsp_type got;
      servo_rsp_type want;
      req_fired = !reset && req_tvalid && req_tready;
      if (req_fired) begin
         expected_results.push_back(predict_frame(req_cur));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tx0 = rsp_tdata[7:0];
         got.tx1 = rsp_tdata[15:8];
         got.tx2 = rsp_tdata[22:16];
         got.tx3 = rsp_tdata[29:23];
         got.tx4 = rsp_tdata[37:30];
         got.tx5 = rsp_tdata[45:38];
         got.status = rsp_tdata[48:46];
         got.ack_word = rsp_tdata[63:49];
         got.sent_position = rsp_tdata[77:64];
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            cmp_field("tx_byte0", want.tx0, got.tx0);
            cmp_field("tx_byte1", want.tx1, got.tx1);
            cmp_field("tx_byte2", want.tx2, got.tx2);
            cmp_field("tx_byte3", want.tx3, got.tx3);
            cmp_field("tx_byte4", want.tx4, got.tx4);
            cmp_field("tx_byte5", want.tx5, got.tx5);
            cmp_field("status", want.status, got.status);
            cmp_field("ack_word", want.ack_word, got.ack_word);
            cmp_field("sent_position", want.sent_position, got.sent_position);
         end
      end
   end

   initial begin
      servo_req_type f;
      logic [7:0] cmd_set[4];
      logic [7:0] rpl_set[4];
      cmd_set = '{COMMAND_CODE_RESET, 8'h00, 8'hFF, 8'($urandom)};
      rpl_set = '{REPLY_CODE_RESET, 8'hFF, 8'h00, 8'($urandom)};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         // phase zero runs on the reset values of both codes
         if (phase != 0) begin
            write_reg(CSR_COMMAND_CODE, cmd_set[phase]);
            write_reg(CSR_REPLY_CODE, rpl_set[phase]);
            @(negedge clock);
            csr_we <= 1'b0;
         end
         calm = (phase == 2);
         @(posedge clock);
         #1;
         if (phase == 0) begin
            pending_frames.push_back(build_frame(8'h00, 14'h0000));
            pending_frames.push_back(build_frame(8'hFF, 14'h3FFF));
            pending_frames.push_back(build_frame(8'hA5, 14'h2AAA));
            pending_frames.push_back(build_frame(8'h5A, 14'h1555));
            f = good_reply(rpl_code, 8'h12, 8'h34, 8'h56);
            pending_frames.push_back(f);
            f.rx_count = 3'd0;
            pending_frames.push_back(f);
            f.rx_count = 3'd1;
            pending_frames.push_back(f);
            f.rx_count = 3'd5;
            pending_frames.push_back(f);
            f.rx_count = 3'd7;
            pending_frames.push_back(f);
            // acknowledge overlap: top bit of the low byte set, bottom bit of the high clear
            pending_frames.push_back(good_reply(rpl_code, 8'h01, 8'hFE, 8'h80));
            pending_frames.push_back(good_reply(rpl_code, 8'hFF, 8'hFF, 8'hFF));
            pending_frames.push_back(good_reply(rpl_code, 8'h00, 8'h00, 8'h00));
            pending_frames.push_back(good_reply(rpl_code + 8'd1, 8'h22, 8'h33, 8'h44));
            pending_frames.push_back(good_reply(8'hFF, 8'h22, 8'h33, 8'h44));
            f = good_reply(rpl_code, 8'h07, 8'h70, 8'h0F);
            f.rx[5] = f.rx[5] ^ 8'h01;
            pending_frames.push_back(f);
            f = good_reply(rpl_code, 8'h07, 8'h70, 8'h0F);
            f.rx[4] = f.rx[4] ^ 8'h80;
            pending_frames.push_back(f);
            // bad CRC takes precedence over a wrong reply code
            f = good_reply(rpl_code ^ 8'h40, 8'h07, 8'h70, 8'h0F);
            f.rx[4] = ~f.rx[4];
            pending_frames.push_back(f);
            f = raw_frame();
            f.op = OP_CHECK;
            f.rx_count = 3'd0;
            pending_frames.push_back(f);
         end
         repeat (PHASE_ITEMS) pending_frames.push_back(random_frame());
         drain();
      end

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
